### hw/rtl/i2cwm_pkg.sv
// ----------------------------------------------------------------------------
// i2cwm_pkg
// Shared types and constants for the write-only I2C line event generator.
// ----------------------------------------------------------------------------
package i2cwm_pkg;

    localparam int OP_W       = 2;
    localparam int ADDR_W     = 7;
    localparam int DATA_W     = 8;
    // data bits per byte; the bit counter reaching this value marks the acknowledge slot
    localparam int BYTE_BITS  = 8;
    localparam int BIT_CNT_W  = 4;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_DATA  = 2'd1,
        OP_STOP  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_BYTE  = 2'd2,
        PH_STOP  = 2'd3
    } t_phase;

    // command as queued between front and back; payload is the byte to shift
    typedef struct packed {
        t_op               op;
        logic [DATA_W-1:0] payload;
    } t_cmd;

    // one line event
    typedef struct packed {
        logic sda;
        logic scl;
        logic hold;
        logic last;
    } t_event;

endpackage

### hw/rtl/i2cwm_front.sv
// ----------------------------------------------------------------------------
// i2cwm_front
// Accepts commands, drops the unused opcode, forms the byte to send and
// queues the command in a two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
module i2cwm_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [i2cwm_pkg::OP_W-1:0]    i_op,
    input  logic [i2cwm_pkg::ADDR_W-1:0]  i_addr,
    input  logic [i2cwm_pkg::DATA_W-1:0]  i_data,
    output logic                          o_cmd_valid,
    input  logic                          i_cmd_ready,
    output i2cwm_pkg::t_cmd               o_cmd
);

    i2cwm_pkg::t_cmd r_mem [2];
    logic            r_wptr;
    logic            r_rptr;
    logic [1:0]      r_count;

    i2cwm_pkg::t_op  op;
    i2cwm_pkg::t_cmd cmd_in;
    logic            push;
    logic            pop;

    assign op      = i2cwm_pkg::t_op'(i_op);
    assign o_ready = (r_count != 2'd2);
    assign push    = i_valid && o_ready && (op != i2cwm_pkg::OP_NONE);
    assign pop     = o_cmd_valid && i_cmd_ready;

    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_mem[r_rptr];

    always_comb begin
        cmd_in.op = op;
        // address goes out shifted left with the write bit clear
        if (op == i2cwm_pkg::OP_START) begin
            cmd_in.payload = {i_addr, 1'b0};
        end else begin
            cmd_in.payload = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

### hw/rtl/i2cwm_back.sv
// ----------------------------------------------------------------------------
// i2cwm_back
// Line event sequencer: walks start, byte and stop sequences, tracks the
// line levels, paces events by the bus hold timer and registers the output.
// ----------------------------------------------------------------------------
module i2cwm_back #(
    parameter int HOLD_CYCLES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  i2cwm_pkg::t_cmd    i_cmd,
    output logic               o_valid,
    input  logic               i_ready,
    output i2cwm_pkg::t_event  o_event
);

    localparam int TMR_W = $clog2(HOLD_CYCLES + 1);

    i2cwm_pkg::t_phase                   r_phase, n_phase;
    logic [1:0]                          r_sub, n_sub;
    logic [i2cwm_pkg::BIT_CNT_W-1:0]     r_bit, n_bit;
    logic [i2cwm_pkg::DATA_W-1:0]        r_shift, n_shift;
    logic                                r_sda, r_scl;
    logic [TMR_W-1:0]                    r_timer;
    logic                                r_o_vld;
    i2cwm_pkg::t_event                   r_o_evt;

    i2cwm_pkg::t_event ev;
    logic              gen;
    logic              is_ack;

    assign o_cmd_ready = (r_phase == i2cwm_pkg::PH_IDLE);
    assign gen = (r_phase != i2cwm_pkg::PH_IDLE) && (r_timer == '0)
                 && (!r_o_vld || i_ready);
    assign is_ack = (r_bit == i2cwm_pkg::BIT_CNT_W'(i2cwm_pkg::BYTE_BITS));

    assign o_valid = r_o_vld;
    assign o_event = r_o_evt;

    always_comb begin
        n_phase = r_phase;
        n_sub   = r_sub;
        n_bit   = r_bit;
        n_shift = r_shift;
        ev.sda  = r_sda;
        ev.scl  = r_scl;
        ev.hold = 1'b1;
        ev.last = 1'b0;
        unique case (r_phase)
            i2cwm_pkg::PH_IDLE: begin
                if (i_cmd_valid) begin
                    n_sub   = 2'd0;
                    n_bit   = '0;
                    n_shift = i_cmd.payload;
                    unique case (i_cmd.op)
                        i2cwm_pkg::OP_START: n_phase = i2cwm_pkg::PH_START;
                        i2cwm_pkg::OP_DATA:  n_phase = i2cwm_pkg::PH_BYTE;
                        i2cwm_pkg::OP_STOP:  n_phase = i2cwm_pkg::PH_STOP;
                        default:             n_phase = i2cwm_pkg::PH_IDLE;
                    endcase
                end
            end
            i2cwm_pkg::PH_START: begin
                unique case (r_sub)
                    2'd0: begin
                        ev.sda = 1'b1;
                        ev.hold = 1'b0;
                    end
                    2'd1: ev.scl = 1'b1;
                    2'd2: ev.sda = 1'b0;
                    default: ev.scl = 1'b0;
                endcase
                if (gen) begin
                    if (r_sub == 2'd3) begin
                        n_phase = i2cwm_pkg::PH_BYTE;
                        n_sub   = 2'd0;
                        n_bit   = '0;
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end
            end
            i2cwm_pkg::PH_BYTE: begin
                unique case (r_sub)
                    2'd0: begin
                        // acknowledge slot releases SDA and holds
                        ev.sda  = is_ack ? 1'b1 : r_shift[i2cwm_pkg::DATA_W-1];
                        ev.hold = is_ack;
                    end
                    2'd1: ev.scl = 1'b1;
                    default: begin
                        ev.scl  = 1'b0;
                        ev.last = is_ack;
                    end
                endcase
                if (gen) begin
                    if (r_sub == 2'd2) begin
                        n_sub = 2'd0;
                        if (is_ack) begin
                            n_phase = i2cwm_pkg::PH_IDLE;
                        end else begin
                            n_bit   = r_bit + 1'b1;
                            n_shift = {r_shift[i2cwm_pkg::DATA_W-2:0], 1'b0};
                        end
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end
            end
            default: begin
                unique case (r_sub)
                    2'd0: begin
                        ev.sda  = 1'b0;
                        ev.hold = 1'b0;
                    end
                    2'd1: ev.scl = 1'b1;
                    default: begin
                        ev.sda  = 1'b1;
                        ev.hold = 1'b0;
                        ev.last = 1'b1;
                    end
                endcase
                if (gen) begin
                    if (r_sub == 2'd2) begin
                        n_phase = i2cwm_pkg::PH_IDLE;
                        n_sub   = 2'd0;
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= i2cwm_pkg::PH_IDLE;
            r_sub   <= 2'd0;
            r_bit   <= '0;
            r_sda   <= 1'b1;
            r_scl   <= 1'b1;
            r_timer <= '0;
            r_o_vld <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_sub   <= n_sub;
            r_bit   <= n_bit;
            if (gen) begin
                r_sda   <= ev.sda;
                r_scl   <= ev.scl;
                r_o_vld <= 1'b1;
            end else if (i_ready) begin
                r_o_vld <= 1'b0;
            end
            if (gen && ev.hold) begin
                r_timer <= TMR_W'(HOLD_CYCLES);
            end else if (r_timer != '0) begin
                r_timer <= r_timer - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        if (gen) begin
            r_o_evt <= ev;
        end
    end

endmodule

### hw/rtl/i2c_write_master_bitbang_top.sv
// ----------------------------------------------------------------------------
// i2c_write_master_bitbang_top
// Write-only I2C master: commands in, SDA/SCL line events out.
// ----------------------------------------------------------------------------
//  Channel   Dir  Carries
//  s_axis    in   command: operation, device address, data byte
//  m_axis    out  line event: SDA, SCL, hold flag; tlast on final event
//
//  Events: start gives 31 events, data byte 27, stop 3. An event flagged
//  hold loads the hold timer with HOLD_CYCLES, and the next event waits
//  until the timer has run out. Picking up a command passes through the
//  idle phase, a step hidden when the previous command ended on a held
//  event.
//  Reset puts both lines released high and empties the command queue.
//  A two-entry command queue lets the input run ahead of the sequencer;
//  output stalls freeze the sequencer, the hold timer keeps counting.
//  Operation 3 is accepted and discarded without any event.
// ----------------------------------------------------------------------------
module i2c_write_master_bitbang_top #(
    parameter int HOLD_CYCLES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] operation, [8:2] device_address, [16:9] data_byte, [23:17] zero
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] sda_line, [1] scl_line, [2] hold_after, [7:3] zero
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast
);

    logic              cmd_valid;
    logic              cmd_ready;
    i2cwm_pkg::t_cmd   cmd;
    i2cwm_pkg::t_event evt;

    // front end: accept, classify and queue commands
    i2cwm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tdata[1:0]),
        .i_addr      (s_axis_tdata[8:2]),
        .i_data      (s_axis_tdata[16:9]),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // back end: event sequencer with bus hold pacing
    i2cwm_back #(
        .HOLD_CYCLES (HOLD_CYCLES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_event     (evt)
    );

    assign m_axis_tdata = {5'b0, evt.hold, evt.scl, evt.sda};
    assign m_axis_tlast = evt.last;

endmodule

### dv/i2c_write_master_bitbang_top_tb.sv
// ----------------------------------------------------------------------------
// i2c_write_master_bitbang_top_tb
// Self-checking bench for the write-only I2C line event generator: bus
// commands go in on the slave stream, every SDA/SCL event coming out of the
// master stream is checked against a line-level model kept in the bench.
// ----------------------------------------------------------------------------
module i2c_write_master_bitbang_top_tb;

    // command as queued for the driver, with the idle gap taken before it
    typedef struct {
        i2cwm_pkg::t_op                    op;
        logic [i2cwm_pkg::ADDR_W-1:0]      addr;
        logic [i2cwm_pkg::DATA_W-1:0]      data;
        int                                gap;
    } t_tb_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [1:0] operation, [8:2] device_address, [16:9] data_byte, [23:17] zero
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [0] sda_line, [1] scl_line, [2] hold_after, [7:3] zero
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    i2c_write_master_bitbang_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Line model: bus levels as the master leaves them, and the events still
    // owed by the block, oldest first.
    // ------------------------------------------------------------------------
    bit                bus_sda = 1'b1;
    bit                bus_scl = 1'b1;
    i2cwm_pkg::t_event line_events_due[$];
    t_tb_cmd           cmd_backlog[$];

    function automatic void emit_event(bit sda, bit scl, bit hold);
        i2cwm_pkg::t_event ev;
        bus_sda  = sda;
        bus_scl  = scl;
        ev.sda   = sda;
        ev.scl   = scl;
        ev.hold  = hold;
        ev.last  = 1'b0;
        line_events_due.push_back(ev);
    endfunction

    // SDA moves leave SCL alone; the hold flag is the caller's choice
    function automatic void drive_sda(bit v, bit hold);
        emit_event(v, bus_scl, hold);
    endfunction

    // every SCL edge is followed by a bus delay
    function automatic void drive_scl(bit v);
        emit_event(bus_sda, v, 1'b1);
    endfunction

    // MSB first, then the acknowledge slot with SDA released (the ack is not sampled)
    function automatic void shift_byte(logic [7:0] b);
        for (int i = 7; i >= 0; i--) begin
            drive_sda(b[i], 1'b0);
            drive_scl(1'b1);
            drive_scl(1'b0);
        end
        drive_sda(1'b1, 1'b1);
        drive_scl(1'b1);
        drive_scl(1'b0);
    endfunction

    function automatic void predict_line_events(t_tb_cmd c);
        case (c.op)
            i2cwm_pkg::OP_START: begin
                // release, then SDA falls while SCL is high
                drive_sda(1'b1, 1'b0);
                drive_scl(1'b1);
                drive_sda(1'b0, 1'b1);
                drive_scl(1'b0);
                shift_byte({c.addr, 1'b0});
            end
            i2cwm_pkg::OP_DATA: begin
                shift_byte(c.data);
            end
            i2cwm_pkg::OP_STOP: begin
                // SDA rises while SCL is high
                drive_sda(1'b0, 1'b0);
                drive_scl(1'b1);
                drive_sda(1'b1, 1'b0);
            end
            default: begin
                // unknown operation: swallowed, no events, levels untouched
            end
        endcase
        if (c.op != i2cwm_pkg::OP_NONE)
            line_events_due[line_events_due.size()-1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Command driver: takes the backlog in order, waits out c.gap before
    // offering each one, and holds tvalid/tdata until the transfer happens.
    // ------------------------------------------------------------------------
    t_tb_cmd  cmd_cur;
    bit       cmd_staged = 1'b0;
    int       cmd_wait   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_line_events(cmd_cur);
                cmd_staged = 1'b0;
            end
            if (!cmd_staged && cmd_backlog.size() != 0) begin
                cmd_cur    = cmd_backlog.pop_front();
                cmd_wait   = cmd_cur.gap;
                cmd_staged = 1'b1;
            end
            if (cmd_staged && cmd_wait == 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'd0, cmd_cur.data, cmd_cur.addr, cmd_cur.op};
            end else begin
                if (cmd_staged)
                    cmd_wait = cmd_wait - 1;
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long receiver hold-off: once a few hundred events have gone by, the
    // sink stops for a long stretch so the command queue fills and the block
    // has to push back on its input.
    // ------------------------------------------------------------------------
    int events_seen    = 0;
    int holdoff_left   = 0;
    bit holdoff_done   = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            holdoff_left <= 0;
            holdoff_done <= 1'b0;
        end else if (!holdoff_done && events_seen >= 300) begin
            holdoff_left <= 2500;
            holdoff_done <= 1'b1;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Event monitor: checks every accepted event against the oldest one due,
    // then draws the stall before the next one. A window of events runs with
    // tready held high throughout.
    // ------------------------------------------------------------------------
    int                stall_left     = 0;
    int                mismatch_count = 0;
    i2cwm_pkg::t_event ev_due;
    i2cwm_pkg::t_event ev_got;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                ev_got.sda  = m_axis_tdata[0];
                ev_got.scl  = m_axis_tdata[1];
                ev_got.hold = m_axis_tdata[2];
                ev_got.last = m_axis_tlast;
                if (line_events_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("event %0d: none due, got sda=%b scl=%b hold=%b last=%b",
                                 events_seen, ev_got.sda, ev_got.scl, ev_got.hold,
                                 ev_got.last);
                end else begin
                    ev_due = line_events_due.pop_front();
                    if (ev_got !== ev_due || m_axis_tdata[7:3] !== 5'd0) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"event %0d: expected sda=%b scl=%b hold=%b last=%b,",
                                      " got sda=%b scl=%b hold=%b last=%b pad=%b"},
                                     events_seen, ev_due.sda, ev_due.scl, ev_due.hold,
                                     ev_due.last, ev_got.sda, ev_got.scl, ev_got.hold,
                                     ev_got.last, m_axis_tdata[7:3]);
                    end
                end
                events_seen <= events_seen + 1;
                stall_left = (events_seen >= 1500 && events_seen < 2200) ?
                             0 : $urandom_range(0, 13);
            end else if (stall_left != 0) begin
                stall_left = stall_left - 1;
            end
            m_axis_tready <= (stall_left == 0) && (holdoff_left == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    bit no_gaps = 1'b0;

    function automatic void queue_cmd(i2cwm_pkg::t_op op,
                                      logic [i2cwm_pkg::ADDR_W-1:0] a,
                                      logic [i2cwm_pkg::DATA_W-1:0] d);
        t_tb_cmd c;
        c.op   = op;
        c.addr = a;
        c.data = d;
        c.gap  = no_gaps ? 0 : $urandom_range(0, 13);
        cmd_backlog.push_back(c);
    endfunction

    function automatic logic [i2cwm_pkg::ADDR_W-1:0] rand_addr();
        return i2cwm_pkg::ADDR_W'($urandom_range(0, 127));
    endfunction

    function automatic logic [i2cwm_pkg::DATA_W-1:0] rand_byte();
        return i2cwm_pkg::DATA_W'($urandom_range(0, 255));
    endfunction

    initial begin
        int counted;
        int n_bytes;
        int seq;

        // directed: data and stop with no start, field extremes, repeated
        // start, double stop, and the unknown operation between real ones
        queue_cmd(i2cwm_pkg::OP_DATA,  7'd0,   8'hA5);
        queue_cmd(i2cwm_pkg::OP_STOP,  7'd0,   8'd0);
        queue_cmd(i2cwm_pkg::OP_START, 7'd0,   8'd0);
        queue_cmd(i2cwm_pkg::OP_DATA,  7'd0,   8'h00);
        queue_cmd(i2cwm_pkg::OP_DATA,  7'd0,   8'hFF);
        queue_cmd(i2cwm_pkg::OP_STOP,  7'd0,   8'd0);
        queue_cmd(i2cwm_pkg::OP_START, 7'd127, 8'hFF);
        queue_cmd(i2cwm_pkg::OP_DATA,  7'd127, 8'hAA);
        queue_cmd(i2cwm_pkg::OP_DATA,  7'd0,   8'h55);
        queue_cmd(i2cwm_pkg::OP_DATA,  7'd0,   8'h01);
        queue_cmd(i2cwm_pkg::OP_DATA,  7'd0,   8'h80);
        queue_cmd(i2cwm_pkg::OP_STOP,  7'd127, 8'hFF);
        queue_cmd(i2cwm_pkg::OP_NONE,  7'd127, 8'hFF);
        queue_cmd(i2cwm_pkg::OP_START, 7'h55,  8'd0);
        queue_cmd(i2cwm_pkg::OP_NONE,  7'd0,   8'd0);
        queue_cmd(i2cwm_pkg::OP_DATA,  7'd0,   8'h3C);
        queue_cmd(i2cwm_pkg::OP_STOP,  7'd0,   8'd0);
        queue_cmd(i2cwm_pkg::OP_STOP,  7'd0,   8'd0);
        queue_cmd(i2cwm_pkg::OP_START, 7'h2A,  8'd0);
        queue_cmd(i2cwm_pkg::OP_START, 7'h2A,  8'd0);
        queue_cmd(i2cwm_pkg::OP_DATA,  7'd0,   8'hC3);
        queue_cmd(i2cwm_pkg::OP_STOP,  7'd0,   8'd0);
        queue_cmd(i2cwm_pkg::OP_NONE,  rand_addr(), rand_byte());

        // random: mostly well-formed writes (start, a few bytes, stop) with
        // random content; the rest stray commands, the unknown one included
        counted = 0;
        seq     = 0;
        while (counted < 137) begin
            no_gaps = (seq >= 12 && seq < 20);
            if ($urandom_range(0, 4) != 0) begin
                queue_cmd(i2cwm_pkg::OP_START, rand_addr(), rand_byte());
                n_bytes = $urandom_range(0, 4);
                for (int i = 0; i < n_bytes; i++)
                    queue_cmd(i2cwm_pkg::OP_DATA, rand_addr(), rand_byte());
                counted += n_bytes + 1;
                // now and then the stop is left out
                if ($urandom_range(0, 7) != 0) begin
                    queue_cmd(i2cwm_pkg::OP_STOP, rand_addr(), rand_byte());
                    counted++;
                end
            end else begin
                i2cwm_pkg::t_op op_r;
                op_r = i2cwm_pkg::t_op'($urandom_range(0, 3));
                queue_cmd(op_r, rand_addr(), rand_byte());
                if (op_r != i2cwm_pkg::OP_NONE)
                    counted++;
            end
            seq++;
        end

        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every command handed over, then every event in, then a further wait
        // to catch anything extra
        while (cmd_backlog.size() != 0 || cmd_staged || s_axis_tvalid)
            @(posedge i_clk);
        while (line_events_due.size() != 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("i2c_write_master_bitbang_top_tb: done, clean");
        else
            $display("i2c_write_master_bitbang_top_tb: done, errors");
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial begin
        #1200000;
        $display("i2c_write_master_bitbang_top_tb: done, errors");
        $finish;
    end

endmodule
